### sv/rth_pkg.sv
// Shared types and constants for the RGB to HSV pixel converter.
// Depends on nothing; the divider and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package rth_pkg;

    localparam int CHAN_W = 8;   // one color channel
    localparam int HUE_W  = 15;  // hue in 1/64 degree
    localparam int SAT_W  = 13;  // saturation, 4096 is full
    localparam int NUM_W  = 20;  // dividend: 3840*255 and 4096*255 fit
    localparam int DEN_W  = CHAN_W;
    localparam int QUO_W  = 13;  // quotients never exceed 4096

    localparam int HUE_SECTOR = 3840;   // 60 degrees
    localparam int HUE_GREEN  = 7680;   // 120 degrees
    localparam int HUE_BLUE   = 15360;  // 240 degrees
    localparam int HUE_FULL   = 23040;  // 360 degrees
    localparam int SAT_SHIFT  = 12;     // times 4096

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [SAT_W-1:0]  saturation;
        logic [CHAN_W-1:0] brightness;
    } t_hsv;

endpackage

`default_nettype wire

### sv/rth_divider.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on rth_pkg for operand and quotient widths.
`timescale 1ns / 1ps
`default_nettype none

module rth_divider
    import rth_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_valid,
    output logic [QUO_W-1:0]      o_quo
);

    logic             r_valid [QUO_W];
    logic [QUO_W-1:0] r_quo   [QUO_W];
    logic [NUM_W-1:0] r_rem   [QUO_W-1];
    logic [DEN_W-1:0] r_den   [QUO_W-1];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int BIT = QUO_W - 1 - k;

        logic             w_valid_in;
        logic [NUM_W-1:0] w_rem_in;
        logic [DEN_W-1:0] w_den_in;
        logic [QUO_W-1:0] w_quo_in;
        logic [NUM_W-1:0] w_trial;
        logic [NUM_W-1:0] n_rem;
        logic [QUO_W-1:0] n_quo;

        if (k == 0) begin : g_first
            assign w_valid_in = i_valid;
            assign w_rem_in   = i_num;
            assign w_den_in   = i_den;
            assign w_quo_in   = '0;
        end else begin : g_next
            assign w_valid_in = r_valid[k-1];
            assign w_rem_in   = r_rem[k-1];
            assign w_den_in   = r_den[k-1];
            assign w_quo_in   = r_quo[k-1];
        end

        assign w_trial = NUM_W'(w_den_in) << BIT;

        always_comb begin
            n_rem = w_rem_in;
            n_quo = w_quo_in;
            if (w_rem_in >= w_trial) begin
                n_rem      = w_rem_in - w_trial;
                n_quo[BIT] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= w_valid_in;
            end
            r_quo[k] <= n_quo;
        end

        // the last stage needs only the quotient
        if (k < QUO_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[k] <= n_rem;
                r_den[k] <= w_den_in;
            end
        end
    end

    assign o_valid = r_valid[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];

endmodule

`default_nettype wire

### sv/rgb_to_hsv_pixel.sv
// RGB to HSV pixel converter: one pixel per clock, fully pipelined.
// Pipeline: a register for max/min and sector, then the two
// one-bit-per-stage dividers, then a register for the hue and saturation assembly.
// Throughput is one pixel every cycle; o_busy stays low, results cannot be stalled.
// Synchronous active-low reset clears the valid bits only; no result is
// produced for any cycle that was inside reset. Depends on rth_pkg, rth_divider.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_pixel
    import rth_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_rgb i_pixel,
    output logic      o_busy,
    output logic      o_valid,
    output t_hsv      o_hsv
);

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    typedef struct packed {
        t_sector           sector;
        logic              neg;
        logic              grey;
        logic              black;
        logic [CHAN_W-1:0] brightness;
    } t_side;

    // ---- front stage: max, min, sector and difference ----
    logic [CHAN_W-1:0] w_mx, w_mn, w_pa, w_pb;
    t_sector           w_sector;

    always_comb begin
        w_mx = i_pixel.red;
        w_mn = i_pixel.red;
        if (i_pixel.green > w_mx) w_mx = i_pixel.green;
        if (i_pixel.blue  > w_mx) w_mx = i_pixel.blue;
        if (i_pixel.green < w_mn) w_mn = i_pixel.green;
        if (i_pixel.blue  < w_mn) w_mn = i_pixel.blue;
        // red wins ties, then green
        if (w_mx == i_pixel.red) begin
            w_sector = SEC_RED;
            w_pa     = i_pixel.green;
            w_pb     = i_pixel.blue;
        end else if (w_mx == i_pixel.green) begin
            w_sector = SEC_GREEN;
            w_pa     = i_pixel.blue;
            w_pb     = i_pixel.red;
        end else begin
            w_sector = SEC_BLUE;
            w_pa     = i_pixel.red;
            w_pb     = i_pixel.green;
        end
    end

    logic              r_s0_valid;
    logic [CHAN_W-1:0] r_s0_mag;
    logic [CHAN_W-1:0] r_s0_delta;
    logic [CHAN_W-1:0] r_s0_mx;
    logic              r_s0_neg;
    t_sector           r_s0_sector;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= i_start && !o_busy;
        end
        r_s0_mag    <= (w_pa >= w_pb) ? (w_pa - w_pb) : (w_pb - w_pa);
        r_s0_neg    <= w_pa < w_pb;
        r_s0_delta  <= w_mx - w_mn;
        r_s0_mx     <= w_mx;
        r_s0_sector <= w_sector;
    end

    // ---- dividers ----
    logic [NUM_W-1:0] w_hue_num, w_sat_num;
    logic             w_hue_valid, w_sat_valid;
    logic [QUO_W-1:0] w_hue_quo, w_sat_quo;

    assign w_hue_num = NUM_W'(HUE_SECTOR) * NUM_W'(r_s0_mag);
    assign w_sat_num = NUM_W'(r_s0_delta) << SAT_SHIFT;

    rth_divider u_hue_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_valid),
        .i_num   (w_hue_num),
        .i_den   (r_s0_delta),
        .o_valid (w_hue_valid),
        .o_quo   (w_hue_quo)
    );

    rth_divider u_sat_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_valid),
        .i_num   (w_sat_num),
        .i_den   (r_s0_mx),
        .o_valid (w_sat_valid),
        .o_quo   (w_sat_quo)
    );

    // side data travels alongside the divider stages
    t_side r_side [QUO_W];
    t_side w_side_in;

    assign w_side_in = '{
        sector:     r_s0_sector,
        neg:        r_s0_neg,
        grey:       r_s0_delta == '0,
        black:      r_s0_mx == '0,
        brightness: r_s0_mx
    };

    always_ff @(posedge i_clk) begin
        r_side[0] <= w_side_in;
        for (int k = 1; k < QUO_W; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    // ---- output stage: place hue in its sector ----
    t_side            w_side;
    logic [HUE_W-1:0] w_t;
    logic [HUE_W-1:0] n_hue;
    logic [SAT_W-1:0] n_sat;

    assign w_side = r_side[QUO_W-1];
    assign w_t    = HUE_W'(w_hue_quo);

    always_comb begin
        case (w_side.sector)
            SEC_RED:   n_hue = w_side.neg ? HUE_W'(HUE_FULL) - w_t : w_t;
            SEC_GREEN: n_hue = w_side.neg ? HUE_W'(HUE_GREEN) - w_t
                                          : HUE_W'(HUE_GREEN) + w_t;
            SEC_BLUE:  n_hue = w_side.neg ? HUE_W'(HUE_BLUE) - w_t
                                          : HUE_W'(HUE_BLUE) + w_t;
            default:   n_hue = '0;
        endcase
        if (w_side.grey) n_hue = '0;
        n_sat = w_side.black ? '0 : SAT_W'(w_sat_quo);
    end

    logic r_valid;
    t_hsv r_hsv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_hue_valid && w_sat_valid;
        end
        r_hsv.hue        <= n_hue;
        r_hsv.saturation <= n_sat;
        r_hsv.brightness <= w_side.brightness;
    end

    assign o_busy  = 1'b0;
    assign o_valid = r_valid;
    assign o_hsv   = r_hsv;

endmodule

`default_nettype wire
